>>> rtl/random_dfs_maze_generator_assert.svh
// ----------------------------------------------------------------------------
// Maze generator assertion macros
// Shorthands for the concurrent checks on the maze generator ports.
// ----------------------------------------------------------------------------
`ifndef RANDOM_DFS_MAZE_GENERATOR_ASSERT_SVH
`define RANDOM_DFS_MAZE_GENERATOR_ASSERT_SVH

// check outside reset
`define RDMG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rdmg check failed");

// check that also holds while reset is asserted
`define RDMG_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("rdmg reset check failed");

`endif

>>> rtl/rdmg_pkg.sv
// ----------------------------------------------------------------------------
// rdmg_pkg
// Shared widths, codes and helper functions of the maze generator.
// ----------------------------------------------------------------------------
`default_nettype none

package rdmg_pkg;

  localparam int ACTION_W  = 2;
  localparam int RAND_W    = 31;
  localparam int COORD_W   = 4;
  localparam int DIR_W     = 2;
  localparam int SIDES_W   = 4;
  localparam int PCT_W     = 7;
  localparam int PCT_MOD   = 100;
  localparam logic [PCT_W-1:0] PCT_RESET = 7'd30;

  typedef enum logic [ACTION_W-1:0] {
    ACT_START  = 2'd0,
    ACT_STEP   = 2'd1,
    ACT_READ   = 2'd2,
    ACT_REVEAL = 2'd3
  } action_e;

  typedef enum logic [DIR_W-1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_RIGHT = 2'd2,
    DIR_LEFT  = 2'd3
  } dir_e;

  function automatic logic [SIDES_W-1:0] side_mask(input logic [DIR_W-1:0] d);
    return SIDES_W'(1) << d;
  endfunction

  function automatic logic [2:0] popcount4(input logic [3:0] v);
    return 3'(v[0]) + 3'(v[1]) + 3'(v[2]) + 3'(v[3]);
  endfunction

  // sel-th set bit of avail, lowest first
  function automatic logic [DIR_W-1:0] pick_dir(input logic [3:0] avail,
                                                input logic [1:0] sel);
    logic [2:0]       cnt;
    logic             found;
    logic [DIR_W-1:0] d;
    cnt   = '0;
    found = 1'b0;
    d     = '0;
    for (int i = 0; i < 4; i++) begin
      if (avail[i]) begin
        if (!found && cnt == {1'b0, sel}) begin
          d     = DIR_W'(i);
          found = 1'b1;
        end
        cnt = cnt + 3'd1;
      end
    end
    return d;
  endfunction

endpackage

`default_nettype wire

>>> rtl/rdmg_req_if.sv
// ----------------------------------------------------------------------------
// rdmg_req_if
// Request channel of the maze generator: valid/ready plus request fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface rdmg_req_if import rdmg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [RAND_W-1:0]   random_a;
  logic [RAND_W-1:0]   random_b;
  logic [COORD_W-1:0]  cell_x;
  logic [COORD_W-1:0]  cell_y;
  logic [DIR_W-1:0]    direction;

  modport source (output valid, action, random_a, random_b, cell_x, cell_y,
                  direction, input ready);
  modport sink (input valid, action, random_a, random_b, cell_x, cell_y,
                direction, output ready);
endinterface

`default_nettype wire

>>> rtl/rdmg_rsp_if.sv
// ----------------------------------------------------------------------------
// rdmg_rsp_if
// Response channel of the maze generator: valid/ready plus result fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface rdmg_rsp_if import rdmg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               generating;
  logic               finished;
  logic [SIDES_W-1:0] connections;
  logic               has_item;
  logic               discovered;
  logic               move_allowed;

  modport source (output valid, generating, finished, connections, has_item,
                  discovered, move_allowed, input ready);
  modport sink (input valid, generating, finished, connections, has_item,
                discovered, move_allowed, output ready);
endinterface

`default_nettype wire

>>> rtl/rdmg_ram.sv
// ----------------------------------------------------------------------------
// rdmg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rdmg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/rdmg_modc.sv
// ----------------------------------------------------------------------------
// rdmg_modc
// Remainder of a random word by a constant: reciprocal multiply, back
// multiply and subtract, final correction, each step registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rdmg_modc import rdmg_pkg::*; #(
  parameter int DIV = 100,
  localparam int RW = $clog2(DIV)
) (
  input  logic              clk_i,
  input  logic [RAND_W-1:0] x_i,
  output logic [RW-1:0]     r_o
);

  localparam int K  = RAND_W + RW;
  localparam int MW = RAND_W + 2;
  localparam logic [63:0] MUL = ((64'd1 << K) + 64'(DIV) - 64'd1) / 64'(DIV);

  logic [RAND_W-1:0] x1_q;
  logic [63:0]       p_q;
  logic [63-K:0]     quo;
  logic [RAND_W-1:0] qd;
  logic [RAND_W-1:0] rem;
  logic [RW:0]       r2_q;
  logic [RW-1:0]     r_q;

  assign quo = p_q[63:K];
  assign qd  = RAND_W'(quo * DIV);
  assign rem = x1_q - qd;

  always_ff @(posedge clk_i) begin
    x1_q <= x_i;
    p_q  <= x_i * MUL[MW-1:0];
    r2_q <= rem[RW:0];
    r_q  <= (r2_q >= (RW+1)'(DIV)) ? RW'(r2_q - (RW+1)'(DIV)) : r2_q[RW-1:0];
  end

  // x1_q and p_q belong to the same word
  assign r_o = r_q;

endmodule

`default_nettype wire

>>> rtl/random_dfs_maze_generator.sv
// ----------------------------------------------------------------------------
// random_dfs_maze_generator
// Depth-first backtracking maze generator on a GRID_SIZE x GRID_SIZE grid.
// ----------------------------------------------------------------------------
// One request is handled at a time; all cell and stack state sits in two
// one-port-read RAMs (cell sides/item plus the path stack, and the visited
// marks), so the request time is set by the number of RAM accesses in
// sequence, after a wait for the remainder units. A read or reveal of a
// cell outside the grid skips the read-back, a start first clears the full
// grid, and the pop that finishes the maze clears the visited marks. The
// next request can be taken in the cycle after the response is loaded.
// After reset a clear of the whole grid runs before the first request is
// taken; configuration writes are taken at any time.
// A finished response can wait on the output while the next request is taken.
`default_nettype none

module random_dfs_maze_generator import rdmg_pkg::*; #(
  parameter int GRID_SIZE = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  rdmg_req_if.sink         req_i,
  rdmg_rsp_if.source       rsp_o,
  input  logic             cfg_we_i,
  input  logic [PCT_W-1:0] cfg_wdata_i
);

  localparam int CW    = $clog2(GRID_SIZE);
  localparam int CELLS = GRID_SIZE * GRID_SIZE;
  localparam int AW    = $clog2(CELLS);
  localparam int CNTW  = $clog2(CELLS + 1);
  localparam int WW    = 2 * CW + 5;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_WAIT, S_START, S_TOPRD, S_TOPGET, S_SCAN, S_PICK,
    S_NBRD, S_NBWR, S_PUSHRD, S_PUSHWR, S_ENTRD, S_ENTWR, S_EXRD, S_EXWR,
    S_SEENCLR, S_SEENENT, S_SEENEX, S_CELL, S_CELLGET, S_RESP
  } state_e;

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] y,
                                              input logic [CW-1:0] x);
    return AW'(int'(y) * GRID_SIZE + int'(x));
  endfunction

  function automatic logic nb_ok(input logic [DIR_W-1:0] d,
                                 input logic [CW-1:0] y, input logic [CW-1:0] x);
    logic ok;
    case (dir_e'(d))
      DIR_UP:    ok = (y != '0);
      DIR_DOWN:  ok = (y != CW'(GRID_SIZE - 1));
      DIR_RIGHT: ok = (x != CW'(GRID_SIZE - 1));
      DIR_LEFT:  ok = (x != '0);
      default:   ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic logic [2*CW-1:0] nb_coord(input logic [DIR_W-1:0] d,
                                               input logic [CW-1:0] y,
                                               input logic [CW-1:0] x);
    logic [2*CW-1:0] c;
    case (dir_e'(d))
      DIR_UP:    c = {y - CW'(1), x};
      DIR_DOWN:  c = {y + CW'(1), x};
      DIR_RIGHT: c = {y, x + CW'(1)};
      DIR_LEFT:  c = {y, x - CW'(1)};
      default:   c = {y, x};
    endcase
    return c;
  endfunction

  state_e             state_q;
  logic [1:0]         wcnt_q;
  logic [AW-1:0]      sweep_q;
  logic               clr_start_q;
  action_e            act_q;
  logic [RAND_W-1:0]  ra_q;
  logic [RAND_W-1:0]  rb_q;
  logic [COORD_W-1:0] cx_q;
  logic [COORD_W-1:0] cy_q;
  logic [DIR_W-1:0]   din_q;
  logic [CNTW-1:0]    count_q;
  logic [CW-1:0]      ent_row_q;
  logic [PCT_W-1:0]   pct_q;
  logic [CW-1:0]      ty_q;
  logic [CW-1:0]      tx_q;
  logic [2:0]         k_q;
  logic [3:0]         avail_q;
  logic [WW-1:0]      topw_q;
  logic [DIR_W-1:0]   pdir_q;
  logic [2*CW-1:0]    nbc_q;
  logic [AW-1:0]      ent_addr_q;
  logic [AW-1:0]      ex_addr_q;
  logic               r_gen_q, r_fin_q, r_item_q, r_seen_q, r_mv_q;
  logic [SIDES_W-1:0] r_conn_q;
  logic               ov_q, o_gen_q, o_fin_q, o_item_q, o_seen_q, o_mv_q;
  logic [SIDES_W-1:0] o_conn_q;

  logic [PCT_W-1:0]   m100;
  logic [1:0]         m3;
  logic [CW-1:0]      ma_g;
  logic [CW-1:0]      mb_g;

  logic               a_we, b_we, b_wdata, b_rdata;
  logic [AW-1:0]      a_waddr, a_raddr, b_waddr, b_raddr;
  logic [WW-1:0]      a_wdata, a_rdata;

  logic [2:0]         n_avail;
  logic [1:0]         sel;
  logic [DIR_W-1:0]   pick;
  logic [AW-1:0]      top_addr;
  logic [AW-1:0]      nb_addr;
  logic [AW-1:0]      c_addr;
  logic               c_in;
  logic               item_hit;
  logic               lone_side;
  logic [CNTW-1:0]    cnt_m1;
  logic [2*CW-1:0]    scan_c;
  logic               out_free;

  rdmg_modc #(.DIV(PCT_MOD))   u_mod100 (.clk_i, .x_i(ra_q), .r_o(m100));
  rdmg_modc #(.DIV(3))         u_mod3   (.clk_i, .x_i(ra_q), .r_o(m3));
  rdmg_modc #(.DIV(GRID_SIZE)) u_moda   (.clk_i, .x_i(ra_q), .r_o(ma_g));
  rdmg_modc #(.DIV(GRID_SIZE)) u_modb   (.clk_i, .x_i(rb_q), .r_o(mb_g));

  rdmg_ram #(.WIDTH(WW), .DEPTH(CELLS)) u_cell_ram (
    .clk_i, .we_i(a_we), .waddr_i(a_waddr), .wdata_i(a_wdata),
    .raddr_i(a_raddr), .rdata_o(a_rdata)
  );

  rdmg_ram #(.WIDTH(1), .DEPTH(CELLS)) u_seen_ram (
    .clk_i, .we_i(b_we), .waddr_i(b_waddr), .wdata_i(b_wdata),
    .raddr_i(b_raddr), .rdata_o(b_rdata)
  );

  assign n_avail   = popcount4(avail_q);
  assign pick      = pick_dir(avail_q, sel);
  assign top_addr  = cell_addr(ty_q, tx_q);
  assign nb_addr   = cell_addr(nbc_q[2*CW-1:CW], nbc_q[CW-1:0]);
  assign c_in      = (int'(cx_q) < GRID_SIZE) && (int'(cy_q) < GRID_SIZE);
  assign c_addr    = cell_addr(CW'(cy_q), CW'(cx_q));
  assign item_hit  = (m100 < pct_q);
  assign lone_side = (popcount4(topw_q[SIDES_W-1:0]) == 3'd1);
  assign cnt_m1    = count_q - CNTW'(1);
  assign scan_c    = nb_coord(k_q[1:0], ty_q, tx_q);
  assign out_free  = !ov_q || rsp_o.ready;

  always_comb begin
    case (n_avail)
      3'd1:    sel = 2'd0;
      3'd2:    sel = {1'b0, ra_q[0]};
      3'd3:    sel = m3;
      default: sel = ra_q[1:0];
    endcase
  end

  always_comb begin
    a_we    = 1'b0;
    a_waddr = top_addr;
    a_wdata = topw_q;
    a_raddr = '0;
    b_we    = 1'b0;
    b_waddr = '0;
    b_wdata = 1'b1;
    b_raddr = '0;
    case (state_q)
      S_CLEAR: begin
        a_we    = 1'b1;
        a_waddr = sweep_q;
        a_wdata = '0;
        b_we    = 1'b1;
        b_waddr = sweep_q;
        b_wdata = 1'b0;
      end
      S_START: begin
        a_we    = 1'b1;
        a_waddr = '0;
        a_wdata = {mb_g, ma_g, 5'b0};
        b_we    = 1'b1;
        b_waddr = cell_addr(mb_g, ma_g);
      end
      S_TOPRD: a_raddr = cnt_m1[AW-1:0];
      S_SCAN: begin
        if (k_q == 3'd0) begin
          a_raddr = top_addr;
        end
        if (k_q != 3'd4 && nb_ok(k_q[1:0], ty_q, tx_q)) begin
          b_raddr = cell_addr(scan_c[2*CW-1:CW], scan_c[CW-1:0]);
        end else begin
          b_raddr = top_addr;
        end
      end
      S_PICK: begin
        if (n_avail != 3'd0) begin
          a_we    = 1'b1;
          a_wdata = topw_q | WW'(side_mask(pick));
        end else if (item_hit && lone_side) begin
          a_we    = 1'b1;
          a_wdata = topw_q | WW'(5'b10000);
        end
      end
      S_NBRD: a_raddr = nb_addr;
      S_NBWR: begin
        a_we    = 1'b1;
        a_waddr = nb_addr;
        a_wdata = a_rdata | WW'(side_mask(pdir_q ^ DIR_W'(1)));
        b_we    = 1'b1;
        b_waddr = nb_addr;
      end
      S_PUSHRD: a_raddr = count_q[AW-1:0];
      S_PUSHWR: begin
        a_we    = 1'b1;
        a_waddr = count_q[AW-1:0];
        a_wdata = {nbc_q, a_rdata[4:0]};
      end
      S_ENTRD: a_raddr = ent_addr_q;
      S_ENTWR: begin
        a_we    = 1'b1;
        a_waddr = ent_addr_q;
        a_wdata = a_rdata | WW'(side_mask(DIR_LEFT));
      end
      S_EXRD: a_raddr = ex_addr_q;
      S_EXWR: begin
        a_we    = 1'b1;
        a_waddr = ex_addr_q;
        a_wdata = a_rdata | WW'(side_mask(DIR_RIGHT));
      end
      S_SEENCLR: begin
        b_we    = 1'b1;
        b_waddr = sweep_q;
        b_wdata = 1'b0;
      end
      S_SEENENT: begin
        b_we    = 1'b1;
        b_waddr = ent_addr_q;
      end
      S_SEENEX: begin
        b_we    = 1'b1;
        b_waddr = ex_addr_q;
      end
      S_CELL: begin
        a_raddr = c_addr;
        b_raddr = c_addr;
        if (c_in && act_q == ACT_REVEAL) begin
          b_we    = 1'b1;
          b_waddr = c_addr;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      wcnt_q      <= '0;
      sweep_q     <= '0;
      clr_start_q <= 1'b0;
      act_q       <= ACT_START;
      ra_q        <= '0;
      rb_q        <= '0;
      cx_q        <= '0;
      cy_q        <= '0;
      din_q       <= '0;
      count_q     <= '0;
      ent_row_q   <= '0;
      pct_q       <= PCT_RESET;
      ty_q        <= '0;
      tx_q        <= '0;
      k_q         <= '0;
      avail_q     <= '0;
      topw_q      <= '0;
      pdir_q      <= '0;
      nbc_q       <= '0;
      ent_addr_q  <= '0;
      ex_addr_q   <= '0;
      r_gen_q     <= 1'b0;
      r_fin_q     <= 1'b0;
      r_conn_q    <= '0;
      r_item_q    <= 1'b0;
      r_seen_q    <= 1'b0;
      r_mv_q      <= 1'b0;
      ov_q        <= 1'b0;
      o_gen_q     <= 1'b0;
      o_fin_q     <= 1'b0;
      o_conn_q    <= '0;
      o_item_q    <= 1'b0;
      o_seen_q    <= 1'b0;
      o_mv_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        pct_q <= cfg_wdata_i;
      end
      if (state_q == S_RESP && out_free) begin
        ov_q <= 1'b1;
      end else if (rsp_o.ready) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          sweep_q <= sweep_q + AW'(1);
          if (sweep_q == AW'(CELLS - 1)) begin
            state_q <= clr_start_q ? S_START : S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_i.valid) begin
            act_q   <= action_e'(req_i.action);
            ra_q    <= req_i.random_a;
            rb_q    <= req_i.random_b;
            cx_q    <= req_i.cell_x;
            cy_q    <= req_i.cell_y;
            din_q   <= req_i.direction;
            wcnt_q  <= '0;
            state_q <= S_WAIT;
          end
        end
        S_WAIT: begin
          wcnt_q <= wcnt_q + 2'd1;
          if (wcnt_q == 2'd2) begin
            r_gen_q  <= 1'b0;
            r_fin_q  <= 1'b0;
            r_conn_q <= '0;
            r_item_q <= 1'b0;
            r_seen_q <= 1'b0;
            r_mv_q   <= 1'b0;
            case (act_q)
              ACT_START: begin
                sweep_q     <= '0;
                clr_start_q <= 1'b1;
                state_q     <= S_CLEAR;
              end
              ACT_STEP:   state_q <= (count_q == '0) ? S_RESP : S_TOPRD;
              default:    state_q <= S_CELL;
            endcase
          end
        end
        S_START: begin
          clr_start_q <= 1'b0;
          count_q     <= CNTW'(1);
          r_gen_q     <= 1'b1;
          state_q     <= S_RESP;
        end
        S_TOPRD: state_q <= S_TOPGET;
        S_TOPGET: begin
          ty_q    <= a_rdata[5+CW +: CW];
          tx_q    <= a_rdata[5 +: CW];
          k_q     <= '0;
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          k_q <= k_q + 3'd1;
          if (k_q == 3'd1) begin
            topw_q <= a_rdata;
          end
          if (k_q != 3'd0) begin
            avail_q[k_q[1:0] - 2'd1] <= nb_ok(k_q[1:0] - 2'd1, ty_q, tx_q) && !b_rdata;
          end
          if (k_q == 3'd4) begin
            state_q <= S_PICK;
          end
        end
        S_PICK: begin
          if (n_avail != 3'd0) begin
            pdir_q  <= pick;
            nbc_q   <= nb_coord(pick, ty_q, tx_q);
            state_q <= S_NBRD;
          end else begin
            count_q <= cnt_m1;
            if (cnt_m1 == '0) begin
              ent_addr_q <= cell_addr(ent_row_q, '0);
              ex_addr_q  <= cell_addr(mb_g, CW'(GRID_SIZE - 1));
              ent_row_q  <= mb_g;
              state_q    <= S_ENTRD;
            end else begin
              r_gen_q <= 1'b1;
              state_q <= S_RESP;
            end
          end
        end
        S_NBRD: state_q <= S_NBWR;
        S_NBWR: begin
          r_gen_q <= 1'b1;
          state_q <= (count_q == CNTW'(CELLS)) ? S_RESP : S_PUSHRD;
        end
        S_PUSHRD: state_q <= S_PUSHWR;
        S_PUSHWR: begin
          count_q <= count_q + CNTW'(1);
          state_q <= S_RESP;
        end
        S_ENTRD: state_q <= S_ENTWR;
        S_ENTWR: state_q <= S_EXRD;
        S_EXRD:  state_q <= S_EXWR;
        S_EXWR: begin
          sweep_q <= '0;
          state_q <= S_SEENCLR;
        end
        S_SEENCLR: begin
          sweep_q <= sweep_q + AW'(1);
          if (sweep_q == AW'(CELLS - 1)) begin
            state_q <= S_SEENENT;
          end
        end
        S_SEENENT: state_q <= S_SEENEX;
        S_SEENEX: begin
          r_fin_q <= 1'b1;
          state_q <= S_RESP;
        end
        S_CELL: begin
          r_gen_q <= (count_q != '0);
          state_q <= c_in ? S_CELLGET : S_RESP;
        end
        S_CELLGET: begin
          r_conn_q <= a_rdata[SIDES_W-1:0];
          r_item_q <= a_rdata[4];
          r_seen_q <= b_rdata || (act_q == ACT_REVEAL);
          r_mv_q   <= a_rdata[din_q];
          state_q  <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            o_gen_q  <= r_gen_q;
            o_fin_q  <= r_fin_q;
            o_conn_q <= r_conn_q;
            o_item_q <= r_item_q;
            o_seen_q <= r_seen_q;
            o_mv_q   <= r_mv_q;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign req_i.ready        = (state_q == S_IDLE);
  assign rsp_o.valid        = ov_q;
  assign rsp_o.generating   = o_gen_q;
  assign rsp_o.finished     = o_fin_q;
  assign rsp_o.connections  = o_conn_q;
  assign rsp_o.has_item     = o_item_q;
  assign rsp_o.discovered   = o_seen_q;
  assign rsp_o.move_allowed = o_mv_q;

endmodule

`default_nettype wire

>>> rtl/rdmg_checker.sv
// ----------------------------------------------------------------------------
// rdmg_checker
// Port-level checks of the maze generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "random_dfs_maze_generator_assert.svh"

module rdmg_checker import rdmg_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               req_valid_i,
  input wire logic               req_ready_i,
  input wire logic               rsp_valid_i,
  input wire logic               rsp_ready_i,
  input wire logic               generating_i,
  input wire logic               finished_i,
  input wire logic [SIDES_W-1:0] connections_i,
  input wire logic               has_item_i,
  input wire logic               discovered_i,
  input wire logic               move_allowed_i
);

  logic [1:0] pend_q;
  logic [1:0] pend_d;
  logic       in_acc;
  logic       out_acc;
  logic       cell_any;

  assign in_acc   = req_valid_i && req_ready_i;
  assign out_acc  = rsp_valid_i && rsp_ready_i;
  assign pend_d   = pend_q + 2'(in_acc) - 2'(out_acc);
  assign cell_any = (connections_i != '0) || has_item_i || discovered_i || move_allowed_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `RDMG_ASSERT_RST(a_rst_quiet, !rst_ni |-> !rsp_valid_i)
  `RDMG_ASSERT(a_fin_stack_empty, rsp_valid_i && finished_i |-> !generating_i)
  `RDMG_ASSERT(a_fin_no_cell, rsp_valid_i && finished_i |-> !cell_any)
  `RDMG_ASSERT(a_rsp_has_req, out_acc |-> pend_q != 2'd0)
  `RDMG_ASSERT(a_rsp_hold, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(connections_i))

endmodule

bind random_dfs_maze_generator rdmg_checker u_rdmg_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .generating_i   (rsp_o.generating),
  .finished_i     (rsp_o.finished),
  .connections_i  (rsp_o.connections),
  .has_item_i     (rsp_o.has_item),
  .discovered_i   (rsp_o.discovered),
  .move_allowed_i (rsp_o.move_allowed)
);

`default_nettype wire
